// ===== hdl/sem_pkg.sv =====
// Shared types and constants for the RGB Sobel edge magnitude block.
package sem_pkg;

    localparam int CHAN_BITS  = 8;
    localparam int NUM_LANES  = 3;
    localparam int GRAD_BITS  = 11;
    localparam int SUM_BITS   = 21;
    localparam int ROOT_STEPS = CHAN_BITS;
    // One gradient stage, one square-sum stage, one stage per result bit.
    localparam int LANE_DEPTH = 2 + ROOT_STEPS;
    localparam int PIX_BITS   = NUM_LANES * CHAN_BITS;
    localparam int IDX_BITS   = 8;
    localparam int DATA_BITS  = 16;

    localparam logic [IDX_BITS-1:0] REG_IMAGE_WIDTH  = 8'd0;
    localparam logic [IDX_BITS-1:0] REG_IMAGE_HEIGHT = 8'd1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [10:0] WIDTH_RESET  = 11'd640;
    localparam logic [15:0] HEIGHT_RESET = 16'd480;

    typedef logic [CHAN_BITS-1:0] chan_t;
    typedef logic [PIX_BITS-1:0] pixel_t;
    typedef logic [2:0][2:0][CHAN_BITS-1:0] sem_win_t;

    typedef struct packed {
        logic  command;
        chan_t pixel_red;
        chan_t pixel_green;
        chan_t pixel_blue;
    } sem_in_t;

    typedef struct packed {
        chan_t out_red;
        chan_t out_green;
        chan_t out_blue;
        logic  frame_end;
    } sem_out_t;

    typedef struct packed {
        logic   border;
        logic   frame_end;
        pixel_t center;
    } sem_meta_t;

endpackage

// ===== hdl/sem_line_store.sv =====
// Two line stores feeding the right-hand column of the 3x3 window.
module sem_line_store
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         take,
    input  logic [$clog2(MAX_WIDTH)-1:0] addr,
    input  pixel_t                       px,
    output pixel_t                       up_rd,
    output pixel_t                       mid_rd
);

    localparam int AW = $clog2(MAX_WIDTH);

    pixel_t upper_mem [MAX_WIDTH];
    pixel_t middle_mem [MAX_WIDTH];

    pixel_t         up_rd_reg;
    pixel_t         mid_rd_reg;
    logic           pend_reg;
    logic [AW-1:0]  pend_addr_reg;

    // The upper store takes the middle value in the cycle after it was read.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mid_rd_reg       <= middle_mem[addr];
            middle_mem[addr] <= px;
            if (pend_reg && pend_addr_reg == addr)
            begin
                up_rd_reg <= mid_rd_reg;
            end
            else
            begin
                up_rd_reg <= upper_mem[addr];
            end
            pend_addr_reg <= addr;
        end
        if (pend_reg)
        begin
            upper_mem[pend_addr_reg] <= mid_rd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= take;
        end
    end

    assign up_rd  = up_rd_reg;
    assign mid_rd = mid_rd_reg;

endmodule

// ===== hdl/sem_lane.sv =====
// One color lane: Sobel gradients, sum of squares and a bitwise rounded root.
module sem_lane
    import sem_pkg::*;
(
    input  logic     clk,
    input  logic     advance,
    input  sem_win_t win,
    output chan_t    mag
);

    logic signed [GRAD_BITS-1:0] gx_next;
    logic signed [GRAD_BITS-1:0] gy_next;
    logic signed [GRAD_BITS-1:0] gx_reg;
    logic signed [GRAD_BITS-1:0] gy_reg;
    logic signed [2*GRAD_BITS-1:0] gx_sq;
    logic signed [2*GRAD_BITS-1:0] gy_sq;
    logic [SUM_BITS-1:0] sum_reg;

    logic [SUM_BITS-1:0] s_reg [ROOT_STEPS];
    chan_t               k_reg [ROOT_STEPS];

    function automatic logic signed [GRAD_BITS-1:0] ext(input chan_t v);
        ext = $signed({{(GRAD_BITS-CHAN_BITS){1'b0}}, v});
    endfunction

    always_comb
    begin
        gx_next = (ext(win[0][2]) + (ext(win[1][2]) <<< 1) + ext(win[2][2]))
                - (ext(win[0][0]) + (ext(win[1][0]) <<< 1) + ext(win[2][0]));
        gy_next = (ext(win[2][0]) + (ext(win[2][1]) <<< 1) + ext(win[2][2]))
                - (ext(win[0][0]) + (ext(win[0][1]) <<< 1) + ext(win[0][2]));
        gx_sq   = gx_reg * gx_reg;
        gy_sq   = gy_reg * gy_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            gx_reg  <= gx_next;
            gy_reg  <= gy_next;
            sum_reg <= SUM_BITS'($unsigned(gx_sq)) + SUM_BITS'($unsigned(gy_sq));
        end
    end

    // Each step decides one result bit, most significant first: keep the
    // trial value k when k*(k-1) is still below the sum of squares.
    for (genvar j = 0; j < ROOT_STEPS; j++)
    begin : g_root
        logic [SUM_BITS-1:0]    s_in;
        chan_t                  k_in;
        chan_t                  trial;
        logic [2*CHAN_BITS-1:0] prod;

        if (j == 0)
        begin : g_first
            assign s_in = sum_reg;
            assign k_in = '0;
        end
        else
        begin : g_rest
            assign s_in = s_reg[j-1];
            assign k_in = k_reg[j-1];
        end

        always_comb
        begin
            trial = k_in | (chan_t'(1) << (ROOT_STEPS - 1 - j));
            prod  = {{CHAN_BITS{1'b0}}, trial} * {{CHAN_BITS{1'b0}}, trial - chan_t'(1)};
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                s_reg[j] <= s_in;
                if (SUM_BITS'(prod) < s_in)
                begin
                    k_reg[j] <= trial;
                end
                else
                begin
                    k_reg[j] <= k_in;
                end
            end
        end
    end

    assign mag = k_reg[ROOT_STEPS-1];

endmodule

// ===== hdl/sobel_edge_magnitude_rgb.sv =====
// Top level of the streaming RGB Sobel edge magnitude block.
// Pixels arrive in raster order, one per beat, and each output beat carries
// the rounded Sobel gradient magnitude of one pixel for red, green and blue,
// or the pixel itself on the frame border (every pixel when the frame is
// narrower or shorter than three). Output pixel m is produced by input beat
// m + width + 1, so the host follows each frame with width + 1 drain beats;
// a drain beat sent while the frame is still arriving is dropped. The block
// accepts one beat per clock while out_stall does not hold it. Each result
// passes through the line store read that loads the window and then through
// three identical color lanes (gradients, sum of squares, then a step for
// each result bit of the rounded square root). The whole pipeline holds
// while a result waits on out_stall. A write to either configuration register
// restarts the frame; a write to any other index is ignored.
module sobel_edge_magnitude_rgb
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  sem_in_t              in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output sem_out_t             out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [IDX_BITS-1:0]  cfg_index,
    input  logic [DATA_BITS-1:0] cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int SW = $clog2(MAX_WIDTH + 2);

    // Configuration registers.
    logic [10:0] width_cfg_reg;
    logic [15:0] height_cfg_reg;
    logic        cfg_write;

    // Frame counters.
    logic [CW-1:0] in_col_reg, in_col_next;
    logic [15:0]   in_row_reg, in_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [15:0]   out_row_reg, out_row_next;
    logic [SW-1:0] slot_reg, slot_next;

    logic [WW-1:0] w_eff;
    logic [15:0]   h_eff;
    logic          accept, in_frame, take, emit, advance;
    logic          out_last_col, out_last_row;
    pixel_t        px;
    pixel_t        up_rd, mid_rd;

    // Window: columns 0 and 1 are flops, column 2 is the line store read
    // data for the upper rows and the newest pixel for the bottom row.
    pixel_t win_reg [3][2];
    pixel_t px_reg;
    pixel_t col2 [3];

    // Pipeline valid and side information, stage 0 being the loaded window.
    logic      vld_reg  [LANE_DEPTH+1];
    sem_meta_t meta_reg [LANE_DEPTH+1];
    sem_meta_t meta_in;

    chan_t mag [NUM_LANES];

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    always_comb
    begin
        if (width_cfg_reg == 11'd0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(width_cfg_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_cfg_reg);
        end
        h_eff = (height_cfg_reg == 16'd0) ? 16'd1 : height_cfg_reg;
    end

    assign advance  = !(vld_reg[LANE_DEPTH] && out_stall);
    assign in_stall = !advance;
    assign accept   = in_valid & ~in_stall;
    assign in_frame = in_row_reg < h_eff;
    assign take     = accept & ~(in_data.command == CMD_DRAIN && in_frame);
    assign px       = (in_data.command == CMD_PIXEL && in_frame)
                    ? {in_data.pixel_blue, in_data.pixel_green, in_data.pixel_red}
                    : '0;
    // Once width + 1 beats of the frame have gone in, every beat emits.
    assign emit         = slot_reg == SW'(w_eff) + SW'(1);
    assign out_last_col = WW'(out_col_reg) == w_eff - WW'(1);
    assign out_last_row = out_row_reg == h_eff - 16'd1;

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        slot_next    = slot_reg;
        if (take)
        begin
            if (!emit)
            begin
                slot_next = slot_reg + SW'(1);
            end
            if (WW'(in_col_reg) + WW'(1) >= w_eff)
            begin
                in_col_next = '0;
                if (in_frame)
                begin
                    in_row_next = in_row_reg + 16'd1;
                end
            end
            else
            begin
                in_col_next = in_col_reg + CW'(1);
            end
            if (emit)
            begin
                if (out_last_row && out_last_col)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                    slot_next    = '0;
                end
                else if (out_last_col)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 16'd1;
                end
                else
                begin
                    out_col_next = out_col_reg + CW'(1);
                end
            end
        end
        if (cfg_write && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT))
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            slot_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= WIDTH_RESET;
            height_cfg_reg <= HEIGHT_RESET;
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            slot_reg       <= '0;
        end
        else
        begin
            if (cfg_write && cfg_index == REG_IMAGE_WIDTH)
            begin
                width_cfg_reg <= cfg_data[10:0];
            end
            if (cfg_write && cfg_index == REG_IMAGE_HEIGHT)
            begin
                height_cfg_reg <= cfg_data;
            end
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            slot_reg    <= slot_next;
        end
    end

    sem_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .addr   (in_col_reg),
        .px     (px),
        .up_rd  (up_rd),
        .mid_rd (mid_rd)
    );

    assign col2[0] = up_rd;
    assign col2[1] = mid_rd;
    assign col2[2] = px_reg;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= col2[r];
            end
            px_reg <= px;
        end
    end

    // The center pixel after the shift is the middle read data before it.
    always_comb
    begin
        meta_in.border    = (out_row_reg == 16'd0) || out_last_row
                          || (out_col_reg == '0) || out_last_col;
        meta_in.frame_end = out_last_row && out_last_col;
        meta_in.center    = mid_rd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LANE_DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            vld_reg[0] <= take & emit;
            for (int i = 1; i <= LANE_DEPTH; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            meta_reg[0] <= meta_in;
            for (int i = 1; i <= LANE_DEPTH; i++)
            begin
                meta_reg[i] <= meta_reg[i-1];
            end
        end
    end

    // Three color lanes work side by side on the same window.
    for (genvar c = 0; c < NUM_LANES; c++)
    begin : g_lane
        sem_win_t lane_win;

        always_comb
        begin
            for (int r = 0; r < 3; r++)
            begin
                lane_win[r][0] = win_reg[r][0][c*CHAN_BITS +: CHAN_BITS];
                lane_win[r][1] = win_reg[r][1][c*CHAN_BITS +: CHAN_BITS];
                lane_win[r][2] = col2[r][c*CHAN_BITS +: CHAN_BITS];
            end
        end

        sem_lane u_lane (
            .clk     (clk),
            .advance (advance),
            .win     (lane_win),
            .mag     (mag[c])
        );
    end

    // Merge: border pixels pass through, interior pixels take the lanes.
    always_comb
    begin
        out_data.frame_end = meta_reg[LANE_DEPTH].frame_end;
        if (meta_reg[LANE_DEPTH].border)
        begin
            out_data.out_red   = meta_reg[LANE_DEPTH].center[0*CHAN_BITS +: CHAN_BITS];
            out_data.out_green = meta_reg[LANE_DEPTH].center[1*CHAN_BITS +: CHAN_BITS];
            out_data.out_blue  = meta_reg[LANE_DEPTH].center[2*CHAN_BITS +: CHAN_BITS];
        end
        else
        begin
            out_data.out_red   = mag[0];
            out_data.out_green = mag[1];
            out_data.out_blue  = mag[2];
        end
    end

    assign out_valid = vld_reg[LANE_DEPTH];

endmodule
